[design/bmre_pkg.sv]
// types and constants shared by the boot mouse report decoder
package bmre_pkg;

   localparam int unsigned NUM_EVENTS = 7;

   localparam logic [1:0] KIND_REL  = 2'd0;
   localparam logic [1:0] KIND_KEY  = 2'd1;
   localparam logic [1:0] KIND_SYNC = 2'd2;

   localparam logic [2:0] CODE_X      = 3'd0;
   localparam logic [2:0] CODE_Y      = 3'd1;
   localparam logic [2:0] CODE_WHEEL  = 3'd2;
   localparam logic [2:0] CODE_LEFT   = 3'd3;
   localparam logic [2:0] CODE_RIGHT  = 3'd4;
   localparam logic [2:0] CODE_MIDDLE = 3'd5;
   localparam logic [2:0] CODE_END    = 3'd6;

   localparam logic [3:0] MIN_LENGTH   = 4'd3;
   localparam logic [3:0] MAX_LENGTH   = 4'd8;
   localparam logic [3:0] WHEEL_LENGTH = 4'd4;

   typedef struct packed {
      logic [7:0]        button_bits;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic signed [7:0] wheel_step;
      logic [3:0]        report_length;
   } req_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [2:0]        event_code;
      logic signed [7:0] event_value;
      logic              last_event;
   } rsp_type;

endpackage

[design/boot_mouse_report_to_events_unit.sv]
// top level: boot protocol mouse report to relative, key and sync events
//
// each accepted report with a length of 3 to 8 bytes and some activity (motion,
// wheel, or any change of the stored button byte) yields a run of items: x, y
// and wheel motion for nonzero values, then left, right and middle key events
// for buttons that changed, then one sync item with last_event set. reports
// with a bad length or no activity yield nothing. the button byte of a report
// that yields a run is stored at accept time, so the next report is compared
// against it at once. each report produces 1 to 7 items, shown by the single
// output register one item a cycle while rsp_ready holds; the next report is
// taken in the same cycle the last pending item moves to the output register,
// so runs follow each other without a gap. a report that yields nothing is
// accepted and dropped.
module boot_mouse_report_to_events_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bmre_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmre_pkg::rsp_type rsp_data
);
   import bmre_pkg::*;

   // pending work for the report being unrolled
   logic [NUM_EVENTS-1:0] pend_mask_ff, pend_mask_in;
   logic signed [7:0]     dx_ff, dy_ff, wh_ff;
   logic [2:0]            btn_ff;
   logic [7:0]            prev_buttons_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  out_free;
   logic                  emit;
   logic [NUM_EVENTS-1:0] pick;
   logic [NUM_EVENTS-1:0] rest;
   logic [2:0]            pick_idx;
   logic                  len_ok;
   logic signed [7:0]     wheel_eff;
   logic [7:0]            changed;
   logic                  active;
   logic [NUM_EVENTS-1:0] new_mask;

   // output slot can take an item this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (pend_mask_ff != '0) && out_free;

   // lowest pending event goes first
   assign pick = pend_mask_ff & (~pend_mask_ff + NUM_EVENTS'(1));
   assign rest = pend_mask_ff & ~pick;

   assign req_ready = (pend_mask_ff == '0) || (emit && (rest == '0));
   assign accept    = req_valid && req_ready;

   // decode of the incoming report
   assign len_ok    = (req_data.report_length >= MIN_LENGTH) &&
                      (req_data.report_length <= MAX_LENGTH);
   assign wheel_eff = (req_data.report_length >= WHEEL_LENGTH) ?
                      req_data.wheel_step : 8'sd0;
   assign changed   = req_data.button_bits ^ prev_buttons_ff;
   assign active    = (req_data.move_x != 8'sd0) || (req_data.move_y != 8'sd0) ||
                      (wheel_eff != 8'sd0) || (changed != 8'd0);

   always_comb begin
      new_mask = '0;
      if (len_ok && active) begin
         new_mask = {1'b1, changed[2:0], wheel_eff != 8'sd0,
                     req_data.move_y != 8'sd0, req_data.move_x != 8'sd0};
      end
   end

   always_comb begin
      pend_mask_in = pend_mask_ff;
      if (accept) begin
         pend_mask_in = new_mask;
      end else if (emit) begin
         pend_mask_in = rest;
      end
   end

   // index of the picked event, at most seven narrow steps
   always_comb begin
      pick_idx = CODE_END;
      for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
         if (pick[i]) begin
            pick_idx = 3'(i);
         end
      end
   end

   // build the outgoing item
   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_data_in.event_code  = pick_idx;
      rsp_data_in.last_event  = 1'b0;
      rsp_data_in.event_kind  = KIND_REL;
      rsp_data_in.event_value = 8'sd0;
      unique case (pick_idx)
         CODE_X: begin
            rsp_data_in.event_value = dx_ff;
         end
         CODE_Y: begin
            rsp_data_in.event_value = dy_ff;
         end
         CODE_WHEEL: begin
            rsp_data_in.event_value = wh_ff;
         end
         CODE_LEFT: begin
            rsp_data_in.event_kind  = KIND_KEY;
            rsp_data_in.event_value = {7'd0, btn_ff[0]};
         end
         CODE_RIGHT: begin
            rsp_data_in.event_kind  = KIND_KEY;
            rsp_data_in.event_value = {7'd0, btn_ff[1]};
         end
         CODE_MIDDLE: begin
            rsp_data_in.event_kind  = KIND_KEY;
            rsp_data_in.event_value = {7'd0, btn_ff[2]};
         end
         default: begin
            rsp_data_in.event_kind = KIND_SYNC;
            rsp_data_in.last_event = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mask_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         prev_buttons_ff <= 8'd0;
      end else begin
         pend_mask_ff <= pend_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         // store the button byte only for reports that produce a run
         if (accept && len_ok && active) begin
            prev_buttons_ff <= req_data.button_bits;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff  <= req_data.move_x;
         dy_ff  <= req_data.move_y;
         wh_ff  <= wheel_eff;
         btn_ff <= req_data.button_bits[2:0];
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
